[rtl/logistic_pacing_interval_trainer_macros.svh]
// ----------------------------------------------------------------------------
// logistic_pacing_interval_trainer_macros
// Assertion helpers for the pacing trainer RTL.
// ----------------------------------------------------------------------------
`ifndef LOGISTIC_PACING_INTERVAL_TRAINER_MACROS_SVH
`define LOGISTIC_PACING_INTERVAL_TRAINER_MACROS_SVH

// same-cycle implication, checked out of reset
`define LPIT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define LPIT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/lpit_pkg.sv]
// ----------------------------------------------------------------------------
// lpit_pkg
// Types, constants and command codes of the pacing interval trainer.
// ----------------------------------------------------------------------------
package lpit_pkg;

  localparam logic [32:0] ONE_Q32    = 33'h1_0000_0000;
  localparam logic [31:0] LN2_Q32    = 32'hB172_17F8;
  localparam logic [33:0] LOG2_3_Q32 = 34'h1_95C0_1A3A;
  localparam logic [32:0] LOG2_E_Q32 = 33'h1_7154_7653;
  localparam logic [20:0] OUT_MAX    = 21'd2000000;
  localparam logic [5:0]  EXP_SHIFT_MAX = 6'd40;
  localparam logic [3:0]  TAYLOR_STEPS  = 4'd12;

  // register reset values
  localparam logic [19:0] FRAME_RESET    = 20'd40000;
  localparam logic [23:0] GROWTH_RESET   = 24'd0;
  localparam logic [23:0] UPPER_RESET    = 24'd655360;
  localparam logic [23:0] POSITION_RESET = 24'd327680;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_FRAME  = 2'd0;
  localparam logic [1:0] REG_GROWTH = 2'd1;
  localparam logic [1:0] REG_UPPER  = 2'd2;

  // datapath commands
  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD, OP_MUL_T3, OP_SET_TW, OP_MUL_V, OP_SET_V, OP_MUL_VR,
    OP_MUL_RK, OP_CORR, OP_EXP_FIN, OP_DIV_W_INIT, OP_DIV_STEP, OP_MUL_SH,
    OP_UPD_POS, OP_MUL_Z, OP_SET_Z, OP_MUL_ZL, OP_SET_ACC, OP_MUL_ZH,
    OP_SET_TI, OP_MUL_DEN, OP_DIV_I_INIT, OP_LOAD_OUT
  } lpit_op_t;

  typedef struct packed {
    lpit_op_t   op;
    logic [3:0] k;
  } lpit_cmd_t;

  typedef struct packed {
    logic in_zero;
  } lpit_sts_t;

  // ceil(2^35 / k) for the series divisors
  function automatic logic [35:0] recip_k(input logic [3:0] k);
    logic [35:0] r;
    unique case (k)
      4'd1:    r = 36'h8_0000_0000;
      4'd2:    r = 36'h4_0000_0000;
      4'd3:    r = 36'h2_AAAA_AAAB;
      4'd4:    r = 36'h2_0000_0000;
      4'd5:    r = 36'h1_9999_999A;
      4'd6:    r = 36'h1_5555_5556;
      4'd7:    r = 36'h1_2492_4925;
      4'd8:    r = 36'h1_0000_0000;
      4'd9:    r = 36'h0_E38E_38E4;
      4'd10:   r = 36'h0_CCCC_CCCD;
      4'd11:   r = 36'h0_BA2E_8BA3;
      4'd12:   r = 36'h0_AAAA_AAAB;
      default: r = 36'h8_0000_0000;
    endcase
    return r;
  endfunction

endpackage

[rtl/lpit_ctrl.sv]
// ----------------------------------------------------------------------------
// lpit_ctrl
// Sequencer that steps the datapath through one coefficient update.
// ----------------------------------------------------------------------------
module lpit_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  logic               m_tready,
  input  lpit_pkg::lpit_sts_t sts,
  output lpit_pkg::lpit_cmd_t cmd
);
  import lpit_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_T3, ST_TSET_W, ST_MV, ST_SETV, ST_VR, ST_RK, ST_CORR,
    ST_EFIN, ST_DIVW_SET, ST_DIV, ST_SH_MUL, ST_SH_UPD, ST_Z_MUL, ST_Z_SET,
    ST_ZL_MUL, ST_ZL_ACC, ST_ZH_MUL, ST_TSET_I, ST_DEN_MUL, ST_DIVI_SET,
    ST_OUT
  } state_t;

  state_t     state;
  logic [3:0] k;
  logic [4:0] cnt;
  logic       phase;   // 0: weight pass, 1: interval pass
  logic       out_free;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  // command decode
  always_comb begin
    cmd.k  = k;
    cmd.op = OP_NOP;
    unique case (state)
      ST_IDLE:     cmd.op = OP_LOAD;
      ST_T3:       cmd.op = OP_MUL_T3;
      ST_TSET_W:   cmd.op = OP_SET_TW;
      ST_MV:       cmd.op = OP_MUL_V;
      ST_SETV:     cmd.op = OP_SET_V;
      ST_VR:       cmd.op = OP_MUL_VR;
      ST_RK:       cmd.op = OP_MUL_RK;
      ST_CORR:     cmd.op = OP_CORR;
      ST_EFIN:     cmd.op = OP_EXP_FIN;
      ST_DIVW_SET: cmd.op = OP_DIV_W_INIT;
      ST_DIV:      cmd.op = OP_DIV_STEP;
      ST_SH_MUL:   cmd.op = OP_MUL_SH;
      ST_SH_UPD:   cmd.op = OP_UPD_POS;
      ST_Z_MUL:    cmd.op = OP_MUL_Z;
      ST_Z_SET:    cmd.op = OP_SET_Z;
      ST_ZL_MUL:   cmd.op = OP_MUL_ZL;
      ST_ZL_ACC:   cmd.op = OP_SET_ACC;
      ST_ZH_MUL:   cmd.op = OP_MUL_ZH;
      ST_TSET_I:   cmd.op = OP_SET_TI;
      ST_DEN_MUL:  cmd.op = OP_MUL_DEN;
      ST_DIVI_SET: cmd.op = OP_DIV_I_INIT;
      ST_OUT:      cmd.op = out_free ? OP_LOAD_OUT : OP_NOP;
      default:     cmd.op = OP_NOP;
    endcase
  end

  // state, counters and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      k        <= TAYLOR_STEPS;
      cnt      <= '0;
      phase    <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tready && !(state == ST_OUT && out_free)) m_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid && !sts.in_zero) begin
            phase <= 1'b0;
            state <= ST_T3;
          end
        end
        ST_T3:     state <= ST_TSET_W;
        ST_TSET_W: state <= ST_MV;
        ST_MV:     state <= ST_SETV;
        ST_SETV: begin
          k     <= TAYLOR_STEPS;
          state <= ST_VR;
        end
        ST_VR:     state <= ST_RK;
        ST_RK:     state <= ST_CORR;
        ST_CORR: begin
          if (k == 4'd1) begin
            state <= ST_EFIN;
          end else begin
            k     <= k - 4'd1;
            state <= ST_VR;
          end
        end
        ST_EFIN:   state <= phase ? ST_DEN_MUL : ST_DIVW_SET;
        ST_DIVW_SET: begin
          cnt   <= 5'd31;
          state <= ST_DIV;
        end
        ST_DIV: begin
          cnt <= cnt - 5'd1;
          if (cnt == 5'd0) state <= phase ? ST_OUT : ST_SH_MUL;
        end
        ST_SH_MUL: state <= ST_SH_UPD;
        ST_SH_UPD: state <= ST_Z_MUL;
        ST_Z_MUL:  state <= ST_Z_SET;
        ST_Z_SET:  state <= ST_ZL_MUL;
        ST_ZL_MUL: state <= ST_ZL_ACC;
        ST_ZL_ACC: state <= ST_ZH_MUL;
        ST_ZH_MUL: state <= ST_TSET_I;
        ST_TSET_I: begin
          phase <= 1'b1;
          state <= ST_MV;
        end
        ST_DEN_MUL: state <= ST_DIVI_SET;
        ST_DIVI_SET: begin
          cnt   <= 5'd20;
          state <= ST_DIV;
        end
        ST_OUT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[rtl/lpit_dp.sv]
// ----------------------------------------------------------------------------
// lpit_dp
// Shared multiplier, exp series, restoring divider and position register.
// ----------------------------------------------------------------------------
module lpit_dp (
  input  logic                clk,
  input  logic                rst,
  input  lpit_pkg::lpit_cmd_t cmd,
  input  logic [15:0]         coefficient,
  input  logic [19:0]         frame_interval_us,
  input  logic [23:0]         master_growth,
  input  logic [23:0]         interval_upper,
  output lpit_pkg::lpit_sts_t sts,
  output logic [20:0]         pacing_interval_us
);
  import lpit_pkg::*;

  logic        neg;
  logic [15:0] mag;
  logic [67:0] mul_p;
  logic [67:0] prod;
  logic [31:0] ma;
  logic [35:0] mb;
  logic [5:0]  exp_n;
  logic [31:0] exp_f;
  logic [31:0] v_q;
  logic [31:0] x_q;
  logic [32:0] r_q;
  logic [32:0] e_q;
  logic [32:0] acc;
  logic [55:0] rem;
  logic [55:0] den;
  logic [31:0] nl;
  logic [23:0] pos;
  logic [47:0] z;

  logic [20:0] two_s;
  logic [20:0] two_s_m1;
  logic [23:0] d_sel;
  logic [32:0] q_est;
  logic [36:0] qk;
  logic [32:0] q_fix;
  logic [17:0] tw_p;
  logic [5:0]  n_w;
  logic [49:0] ti_sum;
  logic [13:0] ti_n;
  logic [5:0]  n_i;
  logic [56:0] dv_t;
  logic [56:0] dv_d;
  logic        dv_ge;
  logic [23:0] shift;

  assign sts.in_zero = (coefficient == 16'd0);

  assign two_s    = {frame_interval_us, 1'b0};
  assign two_s_m1 = two_s - 21'd1;
  assign d_sel    = neg ? (interval_upper - pos) : pos;

  // series divide by k: reciprocal estimate, then one correction
  assign q_est = mul_p[67:35];
  assign qk    = {4'b0, q_est} * {33'b0, cmd.k};
  assign q_fix = (qk > {5'b0, x_q}) ? (q_est - 33'd1) : q_est;

  // exponent split for the weight pass
  assign tw_p = mul_p[49:32];
  assign n_w  = (tw_p[17:12] >= EXP_SHIFT_MAX) ? EXP_SHIFT_MAX : tw_p[17:12];

  // exponent split for the interval pass
  assign ti_sum = {1'b0, mul_p[48:0]} + {17'b0, acc};
  assign ti_n   = ti_sum[49:36];
  assign n_i    = (ti_n >= {8'b0, EXP_SHIFT_MAX}) ? EXP_SHIFT_MAX : ti_n[5:0];

  // restoring divider step
  assign dv_t  = {rem, nl[31]};
  assign dv_ge = (dv_t >= {1'b0, den});
  assign dv_d  = dv_t - {1'b0, den};

  assign shift = mul_p[55:32];

  // multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd.op)
      OP_MUL_T3:  begin ma = {16'b0, mag};           mb = {2'b0, LOG2_3_Q32}; end
      OP_MUL_V:   begin ma = exp_f;                  mb = {4'b0, LN2_Q32};    end
      OP_MUL_VR:  begin ma = v_q;                    mb = {3'b0, r_q};        end
      OP_MUL_RK:  begin ma = mul_p[63:32];           mb = recip_k(cmd.k);     end
      OP_MUL_SH:  begin ma = {8'b0, d_sel};          mb = {4'b0, nl};         end
      OP_MUL_Z:   begin ma = {8'b0, master_growth};  mb = {12'b0, pos};       end
      OP_MUL_ZL:  begin ma = z[31:0];                mb = {3'b0, LOG2_E_Q32}; end
      OP_MUL_ZH:  begin ma = {16'b0, z[47:32]};      mb = {3'b0, LOG2_E_Q32}; end
      OP_MUL_DEN: begin ma = {11'b0, two_s_m1};      mb = {3'b0, e_q};        end
      default:    begin ma = '0;                     mb = '0;                 end
    endcase
  end

  assign prod = {36'b0, ma} * {32'b0, mb};

  // position state
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= POSITION_RESET;
    end else if (cmd.op == OP_UPD_POS) begin
      if (!neg) pos <= pos - shift;
      else if (pos < interval_upper) pos <= pos + shift;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        neg <= coefficient[15];
        mag <= coefficient[15] ? (16'd0 - coefficient) : coefficient;
      end
      OP_MUL_T3, OP_MUL_V, OP_MUL_VR, OP_MUL_SH, OP_MUL_Z, OP_MUL_ZL,
      OP_MUL_ZH, OP_MUL_DEN: begin
        mul_p <= prod;
      end
      OP_MUL_RK: begin
        x_q   <= mul_p[63:32];
        mul_p <= prod;
      end
      OP_SET_TW: begin
        exp_n <= n_w;
        exp_f <= {tw_p[11:0], 20'b0};
      end
      OP_SET_V: begin
        v_q <= mul_p[63:32];
        r_q <= ONE_Q32;
      end
      OP_CORR: begin
        r_q <= ONE_Q32 - q_fix;
      end
      OP_EXP_FIN: begin
        e_q <= (exp_n >= EXP_SHIFT_MAX) ? 33'd0 : (r_q >> exp_n);
      end
      OP_DIV_W_INIT: begin
        den <= {23'b0, ONE_Q32 + e_q};
        rem <= {23'b0, ONE_Q32 - e_q};
        nl  <= '0;
      end
      OP_DIV_STEP: begin
        rem <= dv_ge ? dv_d[55:0] : dv_t[55:0];
        nl  <= {nl[30:0], dv_ge};
      end
      OP_SET_Z: begin
        z <= mul_p[47:0];
      end
      OP_SET_ACC: begin
        acc <= mul_p[64:32];
      end
      OP_SET_TI: begin
        exp_n <= n_i;
        exp_f <= ti_sum[35:4];
      end
      OP_DIV_I_INIT: begin
        den <= {1'b0, mul_p[54:0]} + {23'b0, ONE_Q32};
        rem <= {24'b0, two_s, 11'b0};
        nl  <= '0;
      end
      OP_LOAD_OUT: begin
        if (two_s == 21'd0) pacing_interval_us <= 21'd0;
        else if (nl[20:0] > OUT_MAX) pacing_interval_us <= OUT_MAX;
        else pacing_interval_us <= nl[20:0];
      end
      default: begin
      end
    endcase
  end

endmodule

[rtl/logistic_pacing_interval_trainer.sv]
// ----------------------------------------------------------------------------
// logistic_pacing_interval_trainer
// Per-frame pacing interval from a signed regression coefficient.
// ----------------------------------------------------------------------------
// Input stream s_*: one Q4.12 coefficient per transaction in s_tdata.
// A zero coefficient is accepted and gives no output.
// Any other coefficient updates the stored position and then presents the
// pacing interval on the m_* stream; s_tready rises again as the result is
// loaded, so no new item is taken before the last one is through. The work
// runs the 12-step exp series (on one shared multiplier, run twice) and the
// bit-serial divider (32 steps for the weight, 21 for the interval).
// The result sits in an output register: if the receiver stalls, the block
// holds the finished work until the register is free, then accepts again.
// Registers frame_interval_us (0x0), master_growth (0x4) and interval_upper
// (0x8) are written over the APB port; the user must write them only while
// idle, and the block itself does not enforce this. Reset restores register
// defaults and sets the position to 5.0 (Q8.16).
// ----------------------------------------------------------------------------
`include "logistic_pacing_interval_trainer_macros.svh"

module logistic_pacing_interval_trainer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] coefficient
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [20:0] pacing_interval_us, [23:21] zero
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lpit_pkg::*;

  logic [19:0] frame_interval_us;
  logic [23:0] master_growth;
  logic [23:0] interval_upper;
  logic [20:0] pacing_interval_us;
  lpit_cmd_t   cmd;
  lpit_sts_t   sts;

  assign pready  = 1'b1;
  assign m_tdata = {3'b0, pacing_interval_us};

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_interval_us <= FRAME_RESET;
      master_growth     <= GROWTH_RESET;
      interval_upper    <= UPPER_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        REG_FRAME:  frame_interval_us <= pwdata[19:0];
        REG_GROWTH: master_growth     <= pwdata[23:0];
        REG_UPPER:  interval_upper    <= pwdata[23:0];
        default: begin
        end
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[3:2])
      REG_FRAME:  prdata = {12'b0, frame_interval_us};
      REG_GROWTH: prdata = {8'b0, master_growth};
      REG_UPPER:  prdata = {8'b0, interval_upper};
      default:    prdata = 32'd0;
    endcase
  end

  lpit_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lpit_dp u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .coefficient        (s_tdata),
    .frame_interval_us  (frame_interval_us),
    .master_growth      (master_growth),
    .interval_upper     (interval_upper),
    .sts                (sts),
    .pacing_interval_us (pacing_interval_us)
  );

  // checks
  `LPIT_ASSERT_SAME(a_out_range, m_tvalid, m_tdata <= 24'd2000000, "output out of range")
  `LPIT_ASSERT_NEXT(a_busy_after_item, s_tvalid && s_tready && (s_tdata != 16'd0), !s_tready, "took item while busy")
  `LPIT_ASSERT_NEXT(a_zero_no_work, s_tvalid && s_tready && (s_tdata == 16'd0), s_tready, "zero item started work")

endmodule
